### rtl/gascon_permutation_defines.svh
// Assertion macros for the Gascon permutation RTL, used by gascon_ctrl.
// Each macro expects a clock named clk and a reset named rst in scope.
`ifndef GASCON_PERMUTATION_DEFINES_SVH
`define GASCON_PERMUTATION_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define GASCON_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gascon: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define GASCON_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gascon: next-cycle check failed");

`endif

### rtl/gascon_pkg.sv
// Types and constants shared by the Gascon permutation modules.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package gascon_pkg;

  localparam int unsigned LANE_W  = 64;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned ROUND_W = 4;

  // Upper nibble of the round constant is this value minus the round number.
  localparam logic [ROUND_W-1:0] RC_BASE = 4'hF;

  typedef struct packed {
    logic [LANE_W-1:0]  lane0_in;
    logic [LANE_W-1:0]  lane1_in;
    logic [LANE_W-1:0]  lane2_in;
    logic [LANE_W-1:0]  lane3_in;
    logic [LANE_W-1:0]  lane4_in;
    logic [ROUND_W-1:0] start_round;
  } in_t;

  typedef struct packed {
    logic [LANE_W-1:0] lane0_out;
    logic [LANE_W-1:0] lane1_out;
    logic [LANE_W-1:0] lane2_out;
    logic [LANE_W-1:0] lane3_out;
    logic [LANE_W-1:0] lane4_out;
  } out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic               load;
    logic               step;
    logic               store;
    logic [ROUND_W-1:0] round;
  } cmd_t;

endpackage

`default_nettype wire

### rtl/gascon_dp.sv
// Datapath of the Gascon permutation: state register, one round of logic
// and the result register. Depends on gascon_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gascon_dp (
  input  wire logic             clk,
  input  wire gascon_pkg::in_t  item,
  input  wire gascon_pkg::cmd_t cmd,
  output gascon_pkg::out_t      result
);

  typedef logic [4:0][gascon_pkg::WORD_W-1:0] word5_t;
  typedef logic [4:0][gascon_pkg::LANE_W-1:0] lanes_t;

  localparam int unsigned ROT_A [5] = '{19, 61, 1, 10, 7};
  localparam int unsigned ROT_B [5] = '{28, 38, 6, 17, 40};

  lanes_t lanes;
  lanes_t lanes_next;

  // Rotate a 32-bit word right.
  function automatic logic [31:0] ror32(logic [31:0] x, int unsigned n);
    logic [63:0] dbl;
    dbl = {x, x} >> (n % 32);
    return dbl[31:0];
  endfunction

  // Rotate an interleaved 64-bit word right; low half even bits, high half odd.
  function automatic logic [63:0] irot(logic [63:0] w, int unsigned amt);
    int unsigned k;
    logic [63:0] y;
    k = (amt / 2) % 32;
    if ((amt % 2) == 0) begin
      y = {ror32(w[63:32], k), ror32(w[31:0], k)};
    end else begin
      y = {ror32(w[31:0], (k + 1) % 32), ror32(w[63:32], k)};
    end
    return y;
  endfunction

  // Five-bit substitution layer, bitsliced over 32 columns.
  function automatic word5_t sbox(word5_t xi);
    word5_t x;
    logic [31:0] t0, t1, t2, t3, t4;
    x = xi;
    x[0] = x[0] ^ x[4];
    x[2] = x[2] ^ x[1];
    x[4] = x[4] ^ x[3];
    t0 = ~x[0] & x[1];
    t1 = ~x[1] & x[2];
    t2 = ~x[2] & x[3];
    t3 = ~x[3] & x[4];
    t4 = ~x[4] & x[0];
    x[0] = x[0] ^ t1;
    x[1] = x[1] ^ t2;
    x[2] = x[2] ^ t3;
    x[3] = x[3] ^ t4;
    x[4] = x[4] ^ t0;
    x[1] = x[1] ^ x[0];
    x[3] = x[3] ^ x[2];
    x[0] = x[0] ^ x[4];
    x[2] = ~x[2];
    return x;
  endfunction

  // One round: constant addition, substitution on both halves, diffusion.
  always_comb begin
    word5_t lo;
    word5_t hi;
    logic [63:0] w;
    for (int i = 0; i < 5; i++) begin
      lo[i] = lanes[i][31:0];
      hi[i] = lanes[i][63:32];
    end
    lo[2] = lo[2] ^ {24'd0, gascon_pkg::RC_BASE - cmd.round, cmd.round};
    lo = sbox(lo);
    hi = sbox(hi);
    for (int i = 0; i < 5; i++) begin
      w = {hi[i], lo[i]};
      lanes_next[i] = w ^ irot(w, ROT_A[i]) ^ irot(w, ROT_B[i]);
    end
  end

  // State register: loaded from the item, then advanced one round per step.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      lanes[0] <= item.lane0_in;
      lanes[1] <= item.lane1_in;
      lanes[2] <= item.lane2_in;
      lanes[3] <= item.lane3_in;
      lanes[4] <= item.lane4_in;
    end else if (cmd.step) begin
      lanes <= lanes_next;
    end
  end

  // Result register, separate from the state so a new item can start.
  always_ff @(posedge clk) begin
    if (cmd.store) begin
      result.lane0_out <= lanes[0];
      result.lane1_out <= lanes[1];
      result.lane2_out <= lanes[2];
      result.lane3_out <= lanes[3];
      result.lane4_out <= lanes[4];
    end
  end

endmodule

`default_nettype wire

### rtl/gascon_ctrl.sv
// Controller of the Gascon permutation: round counter, run state and the
// result valid flag. Depends on gascon_pkg and gascon_permutation_defines.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "gascon_permutation_defines.svh"

module gascon_ctrl #(
  parameter int unsigned ROUND_LIMIT = 12
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              item_valid,
  output logic                                   item_ready,
  input  wire logic [gascon_pkg::ROUND_W-1:0]    start_round,
  output logic                                   result_valid,
  input  wire logic                              result_ready,
  output gascon_pkg::cmd_t                       cmd
);

  localparam logic [gascon_pkg::ROUND_W-1:0] LIMIT = gascon_pkg::ROUND_W'(ROUND_LIMIT);

  typedef enum logic {
    IDLE,
    RUN
  } state_t;

  state_t                           state;
  logic [gascon_pkg::ROUND_W-1:0]   round;
  logic                             rounds_left;

  // Command decode.
  always_comb begin
    rounds_left = (round < LIMIT);
    item_ready  = (state == IDLE);
    cmd.load    = item_valid && (state == IDLE);
    cmd.step    = (state == RUN) && rounds_left;
    cmd.store   = (state == RUN) && !rounds_left && (!result_valid || result_ready);
    cmd.round   = round;
  end

  // State, round counter and result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= IDLE;
      round        <= '0;
      result_valid <= 1'b0;
    end else begin
      case (state)
        IDLE: begin
          if (cmd.load) begin
            state <= RUN;
            round <= start_round;
          end
        end
        RUN: begin
          if (cmd.step) begin
            round <= round + 1'b1;
          end else if (cmd.store) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
      if (cmd.store) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // A started item always enters the round loop.
  `GASCON_ASSERT_NEXT(a_load_runs, cmd.load, state == RUN)
  // Each step advances the round number by exactly one.
  `GASCON_ASSERT_NEXT(a_step_counts, cmd.step, round == $past(round) + 4'd1)
  // The result register is never overwritten while it holds an untaken result.
  `GASCON_ASSERT_NOW(a_store_free, cmd.store, !result_valid || result_ready)
  // Stepping never coincides with storing or loading.
  `GASCON_ASSERT_NOW(a_step_store, cmd.step, !cmd.store && !cmd.load)

endmodule

`default_nettype wire

### rtl/gascon_permutation.sv
// Gascon permutation, 320-bit state in bit-interleaved form, round-iterative.
// Usage notes:
//   The input channel (item_valid/item_ready/item) carries five 64-bit lanes,
//   each with even bits in the low word and odd bits in the high word, and
//   the first round number. Rounds start_round through ROUND_LIMIT-1 run;
//   a start at or above ROUND_LIMIT returns the lanes unchanged.
//   The output channel (result_valid/result_ready/result) returns one item
//   of five permuted lanes per input item, in order.
//   The item runs its rounds in the state register, one round per step;
//   when the rounds are done and the result register is free, the state
//   moves into the result register and result_valid rises. One state
//   register and one round unit serve a single item at a time; the next
//   item is accepted once the previous one is in the result register.
//   A finished result waits in its own register; the next item is accepted
//   while it waits. If the receiver stalls with a result pending, the next
//   item finishes its rounds and holds until the result register frees.
//   Reset (rst, synchronous) empties the block; no item is in flight after it.
// Depends on gascon_pkg, gascon_ctrl and gascon_dp.
`timescale 1ns / 1ps
`default_nettype none

module gascon_permutation #(
  parameter int unsigned ROUND_LIMIT = 12
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             item_valid,
  output logic                  item_ready,
  input  wire gascon_pkg::in_t  item,
  output logic                  result_valid,
  input  wire logic             result_ready,
  output gascon_pkg::out_t      result
);

  gascon_pkg::cmd_t cmd;

  // Sequencer for rounds and the output handshake.
  gascon_ctrl #(
    .ROUND_LIMIT (ROUND_LIMIT)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .start_round  (item.start_round),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .cmd          (cmd)
  );

  // State register and round logic.
  gascon_dp u_dp (
    .clk    (clk),
    .item   (item),
    .cmd    (cmd),
    .result (result)
  );

endmodule

`default_nettype wire

### sim/tb_gascon_permutation.sv
// Self-checking testbench for gascon_permutation: a 320-bit interleaved permutation.
// It predicts each result in SystemVerilog and checks it against the results the block returns.
// Depends on gascon_pkg and the gascon_permutation RTL.
`timescale 1ns / 1ps

module tb_gascon_permutation;

  localparam int unsigned ROUND_LIMIT = 12;
  localparam int unsigned CLK_HALF    = 4;
  localparam int unsigned RESET_CYCLES = 10;
  localparam int unsigned RANDOM_ITEMS = 1600;
  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned SETTLE_CYCLES = 20;
  localparam int unsigned LONG_HOLD    = 300;

  // Right-rotation amounts of the two diffusion terms, one per lane.
  localparam int unsigned DIFF_ROT_A [5] = '{19, 61, 1, 10, 7};
  localparam int unsigned DIFF_ROT_B [5] = '{28, 38, 6, 17, 40};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_ready;
  gascon_pkg::in_t  item = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  gascon_pkg::out_t result;

  gascon_pkg::out_t permuted_queue[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned hold_cycles = 0;
  logic        no_idle = 1'b0;

  gascon_permutation #(
    .ROUND_LIMIT(ROUND_LIMIT)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item(item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result)
  );

  initial begin
    forever #(CLK_HALF) clk = ~clk;
  end

  // Predictor.

  function automatic logic [31:0] ror32(logic [31:0] x, int unsigned n);
    int unsigned s;
    s = n % 32;
    return (x >> s) | (x << ((32 - s) % 32));
  endfunction

  // Rotate a 64-bit word right, with the word held as even and odd halves.
  // Returns {odd, even}.
  function automatic logic [63:0] rotr_split(logic [31:0] ev, logic [31:0] od,
                                             int unsigned amt);
    int unsigned k;
    k = (amt >> 1) % 32;
    if (amt % 2 == 0) begin
      return {ror32(od, k), ror32(ev, k)};
    end
    return {ror32(ev, (k + 1) % 32), ror32(od, k)};
  endfunction

  // Five-bit substitution applied bitwise across five 32-bit words.
  function automatic logic [4:0][31:0] sbox5(logic [4:0][31:0] x);
    logic [4:0][31:0] t;
    x[0] ^= x[4];
    x[2] ^= x[1];
    x[4] ^= x[3];
    for (int i = 0; i < 5; i++) begin
      t[i] = ~x[i] & x[(i + 1) % 5];
    end
    for (int i = 0; i < 5; i++) begin
      x[i] ^= t[(i + 1) % 5];
    end
    x[1] ^= x[0];
    x[3] ^= x[2];
    x[0] ^= x[4];
    x[2] = ~x[2];
    return x;
  endfunction

  function automatic gascon_pkg::out_t permute(gascon_pkg::in_t it);
    logic [4:0][31:0] ev;
    logic [4:0][31:0] od;
    logic [4:0][63:0] lanes;
    logic [63:0]      rot_a;
    logic [63:0]      rot_b;
    logic [3:0]       rnd;
    lanes = {it.lane4_in, it.lane3_in, it.lane2_in, it.lane1_in, it.lane0_in};
    for (int i = 0; i < 5; i++) begin
      ev[i] = lanes[i][31:0];
      od[i] = lanes[i][63:32];
    end
    rnd = it.start_round;
    while (rnd < ROUND_LIMIT) begin
      ev[2] ^= {24'h0, gascon_pkg::RC_BASE - rnd, rnd};
      ev = sbox5(ev);
      od = sbox5(od);
      for (int i = 0; i < 5; i++) begin
        rot_a = rotr_split(ev[i], od[i], DIFF_ROT_A[i]);
        rot_b = rotr_split(ev[i], od[i], DIFF_ROT_B[i]);
        ev[i] ^= rot_a[31:0] ^ rot_b[31:0];
        od[i] ^= rot_a[63:32] ^ rot_b[63:32];
      end
      rnd++;
    end
    for (int i = 0; i < 5; i++) begin
      lanes[i] = {od[i], ev[i]};
    end
    return '{lane0_out: lanes[0], lane1_out: lanes[1], lane2_out: lanes[2],
             lane3_out: lanes[3], lane4_out: lanes[4]};
  endfunction

  // Stimulus helpers.

  // Idle length: mostly none, some short, a few long.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (no_idle) begin
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 65) begin
      return 0;
    end else if (roll < 90) begin
      return $urandom_range(1, 3);
    end else if (roll < 98) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [63:0] rand_lane();
    int unsigned roll;
    roll = $urandom_range(0, 31);
    if (roll == 0) begin
      return '0;
    end else if (roll == 1) begin
      return '1;
    end
    return {$urandom, $urandom};
  endfunction

  function automatic gascon_pkg::in_t rand_item(logic [3:0] start);
    return '{lane0_in: rand_lane(), lane1_in: rand_lane(), lane2_in: rand_lane(),
             lane3_in: rand_lane(), lane4_in: rand_lane(), start_round: start};
  endfunction

  // Offers one item after an optional gap and returns at the edge that accepts it.
  // Valid is left high so a back-to-back item follows without a bubble.
  task automatic send_item(input gascon_pkg::in_t it, input int unsigned gap);
    if (gap != 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    permuted_queue.push_back(permute(it));
  endtask

  // Stops offering items and waits until every predicted result has come back.
  task automatic drain_results();
    item_valid <= 1'b0;
    do @(posedge clk); while (permuted_queue.size() != 0);
  endtask

  // Tests.

  task automatic test_extremes();
    send_item('{default: '0}, 0);
    send_item('{lane0_in: '1, lane1_in: '1, lane2_in: '1, lane3_in: '1,
                lane4_in: '1, start_round: 4'd0}, pick_gap());
    send_item('{lane0_in: {16{4'hA}}, lane1_in: {16{4'h5}}, lane2_in: {16{4'hA}},
                lane3_in: {16{4'h5}}, lane4_in: {16{4'hA}}, start_round: 4'd0}, pick_gap());
    send_item('{lane0_in: {32'hFFFF_FFFF, 32'h0}, lane1_in: {32'h0, 32'hFFFF_FFFF},
                lane2_in: 64'h8000_0000_0000_0001, lane3_in: 64'h1,
                lane4_in: 64'h8000_0000_0000_0000, start_round: 4'd0}, pick_gap());
    // Late start on all ones: the lanes must come back untouched.
    send_item('{lane0_in: '1, lane1_in: '1, lane2_in: '1, lane3_in: '1,
                lane4_in: '1, start_round: 4'hF}, pick_gap());
    send_item('{default: '0, start_round: 4'd11}, pick_gap());
    drain_results();
  endtask

  // Every start value, including the late starts that run no round.
  task automatic test_start_rounds();
    for (int r = 0; r < 16; r++) begin
      send_item(rand_item(4'(r)), pick_gap());
    end
    drain_results();
  endtask

  // The receiver holds off for a long stretch while items keep coming,
  // so the block fills and stalls its input; then the sender pauses
  // until all results are back and sends another burst.
  task automatic test_stall_and_drain();
    hold_cycles = LONG_HOLD;
    for (int n = 0; n < 12; n++) begin
      send_item(rand_item(4'(n % 13)), 0);
    end
    drain_results();
    for (int n = 0; n < 6; n++) begin
      send_item(rand_item(4'd0), 0);
    end
    drain_results();
  endtask

  task automatic test_random();
    logic [3:0] start;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // Every few hundred items, a stretch with no idling on either side.
      no_idle = (n % 300) >= 240;
      if ($urandom_range(0, 3) == 0) begin
        start = 4'($urandom_range(0, 15));
      end else begin
        start = 4'd0;
      end
      send_item(rand_item(start), pick_gap());
    end
    no_idle = 1'b0;
    drain_results();
  endtask

  // Main sequence.
  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    test_extremes();
    test_start_rounds();
    test_stall_and_drain();
    test_random();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Result checking.

  task automatic check_lane(input string name, input logic [63:0] exp_val,
                            input logic [63:0] got_val);
    if (got_val !== exp_val) begin
      $error("%s: expected %h, got %h", name, exp_val, got_val);
      mismatch_count++;
    end
  endtask

  // Receiver: compares each accepted item with the oldest prediction and
  // drives result_ready with random stalls and the long hold when asked.
  always @(posedge clk) begin
    gascon_pkg::out_t exp_res;
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        if (permuted_queue.size() == 0) begin
          $error("result item with no prediction waiting: %h", result);
          mismatch_count++;
        end else begin
          exp_res = permuted_queue.pop_front();
          check_lane("lane0_out", exp_res.lane0_out, result.lane0_out);
          check_lane("lane1_out", exp_res.lane1_out, result.lane1_out);
          check_lane("lane2_out", exp_res.lane2_out, result.lane2_out);
          check_lane("lane3_out", exp_res.lane3_out, result.lane3_out);
          check_lane("lane4_out", exp_res.lane4_out, result.lane4_out);
        end
      end
      if (hold_cycles != 0) begin
        hold_cycles--;
        result_ready <= 1'b0;
      end else if (!result_ready) begin
        result_ready <= 1'b1;
      end else if (pick_gap() != 0) begin
        hold_cycles = pick_gap();
        result_ready <= 1'b0;
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

endmodule
